// ===== sv/ilb_pkg.sv =====
// Package for the indexed list buffer: op and status codes, defaults.
`default_nettype none
package ilb_pkg;
	localparam int CapacityDef = 16;
	localparam int RecordBitsDef = 32;

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_GET    = 3'd3,
		OP_FIND   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOTFND  = 2'd3
	} status_t;
endpackage
`default_nettype wire

// ===== sv/indexed_list_buffer.sv =====
// Top level of the indexed list buffer: sequencer around one record RAM.
// Usage: a request (op, position, record, match_order) enters on in_valid
// while in_stall is low; exactly one result (status, read_record,
// found_index, count) leaves on out_valid, held while out_stall is high.
// The records sit in one RAM, position 0 at the head. Each request is run
// by a sequencer. Insert and remove walk the RAM entry by entry, each step
// a read (S_READ) then a write back (S_SHIFT); find compares one entry per
// cycle in S_FIND. These requests finish in the accepting cycle, with no
// walk: append, clear, unused codes, full/range errors, insert at or past
// the tail, remove of the last record, and find on an empty list or with
// find_enabled low. Get reads its record in S_GET. Insert at p below
// count moves the count-p records from p up; remove at p moves the
// count-1-p records above p; find checks up to count records. Here count
// is taken before the request.
// The RAM port and its registered read data set these steps.
// One request is in work at a time; a new request is taken once the
// result register is empty or being drained, so a stalled receiver holds
// the result and blocks further intake. Reset empties the list (zero
// fill; the count output and RAM content are left undefined) and sets
// find_enabled to one, written through find_enabled_we/find_enabled_wdata.
`default_nettype none
module indexed_list_buffer import ilb_pkg::*; #(
	parameter int CAPACITY = CapacityDef,
	parameter int RECORD_BITS = RecordBitsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        find_enabled_we,
	input  wire logic        find_enabled_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [7:0]  position,
	input  wire logic [31:0] record,
	input  wire logic [7:0]  match_order,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [31:0]      read_record,
	output logic [7:0]       found_index,
	output logic [8:0]       count
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_SHIFT = 5'b00100,
		S_FIND  = 5'b01000,
		S_GET   = 5'b10000
	} state_t;

	state_t                 state_q;
	logic                   find_en_q;
	logic [CW-1:0]          fill_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          pos_q;
	logic [7:0]             seen_q;
	logic [7:0]             order_q;
	logic [RECORD_BITS-1:0] rec_q;
	logic                   ins_q;

	logic                   we;
	logic [AW-1:0]          waddr, raddr;
	logic [RECORD_BITS-1:0] wdata, rdata;

	ilb_ram #(.WIDTH(RECORD_BITS), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic accept, done;
	logic [1:0] st_d;
	logic [31:0] rd_d;
	logic [7:0] fi_d;
	logic [CW-1:0] fill_d;
	logic [CW-1:0] pos_in;
	logic pos_ge;
	logic [RECORD_BITS-1:0] key_in;

	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);
	assign accept = in_valid && !in_stall;
	// Positions that exceed the counter width are always beyond the fill.
	assign pos_ge = ({1'b0, position} >= 9'(fill_q));
	assign pos_in = CW'(position);
	assign key_in = RECORD_BITS'(record);

	always_comb begin
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		done = 1'b0;
		st_d = ST_OK;
		rd_d = '0;
		fi_d = '0;
		fill_d = fill_q;
		if (accept) begin
			// Start-of-request: simple ops finish now.
			unique case (op)
				OP_APPEND, OP_INSERT: begin
					if (fill_q >= CW'(CAPACITY)) begin
						done = 1'b1;
						st_d = ST_FULL;
					end else if (op == OP_APPEND || pos_ge) begin
						we = 1'b1;
						waddr = fill_q[AW-1:0];
						wdata = key_in;
						done = 1'b1;
						fill_d = fill_q + 1'b1;
					end
				end
				OP_REMOVE: begin
					if (pos_ge) begin
						done = 1'b1;
						st_d = ST_RANGE;
					end else if (fill_q == pos_in + 1'b1) begin
						done = 1'b1;
						fill_d = fill_q - 1'b1;
					end
				end
				OP_GET: begin
					raddr = pos_in[AW-1:0];
					if (pos_ge) begin
						done = 1'b1;
						st_d = ST_RANGE;
					end
				end
				OP_FIND: begin
					raddr = '0;
					if (!find_en_q || fill_q == '0) begin
						done = 1'b1;
						st_d = ST_NOTFND;
					end
				end
				OP_CLEAR: begin
					done = 1'b1;
					fill_d = '0;
				end
				default: done = 1'b1;
			endcase
		end else begin
			unique case (state_q)
				S_GET: begin
					done = 1'b1;
					rd_d = 32'(rdata);
				end
				S_READ: begin
					// Read issue for the shift walk.
				end
				S_SHIFT: begin
					we = 1'b1;
					if (ins_q) begin
						// rdata = cell[idx-1], written to cell[idx]
						if (idx_q == pos_q) begin
							wdata = rec_q;
							done = 1'b1;
							fill_d = fill_q + 1'b1;
						end
					end else begin
						// rdata = cell[idx+1], written to cell[idx]
						if (idx_q + 2'd2 >= fill_q) begin
							done = 1'b1;
							fill_d = fill_q - 1'b1;
						end
					end
				end
				S_FIND: begin
					// rdata = cell[idx]
					if (rdata == rec_q && seen_q == order_q) begin
						done = 1'b1;
						fi_d = 8'(idx_q);
					end else if (idx_q + 1'b1 >= fill_q) begin
						done = 1'b1;
						st_d = ST_NOTFND;
					end
				end
				default: ;
			endcase
			if (state_q == S_READ) begin
				raddr = ins_q ? AW'(idx_q - 1'b1) : AW'(idx_q + 1'b1);
			end
			if (state_q == S_FIND) begin
				raddr = AW'(idx_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			find_en_q <= 1'b1;
			fill_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (find_enabled_we) begin
				find_en_q <= find_enabled_wdata;
			end
			fill_q <= fill_d;
			// Drop the result once taken, raise it when a request finishes.
			if (done) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (done) begin
				state_q <= S_IDLE;
			end else if (accept) begin
				unique case (op)
					OP_GET:  state_q <= S_GET;
					OP_FIND: state_q <= S_FIND;
					default: state_q <= S_READ;
				endcase
			end else begin
				unique case (state_q)
					S_READ:  state_q <= S_SHIFT;
					S_SHIFT: state_q <= S_READ;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status <= st_d;
			read_record <= rd_d;
			found_index <= fi_d;
			count <= 9'(fill_d);
		end
		if (accept) begin
			rec_q <= key_in;
			order_q <= match_order;
			pos_q <= pos_in;
			seen_q <= '0;
			ins_q <= (op == OP_INSERT);
			// Insert walks down from the tail, remove walks up from position.
			idx_q <= (op == OP_INSERT) ? fill_q : (op == OP_FIND ? '0 : pos_in);
		end else if (state_q == S_SHIFT) begin
			idx_q <= ins_q ? idx_q - 1'b1 : idx_q + 1'b1;
		end else if (state_q == S_FIND) begin
			if (rdata == rec_q) begin
				seen_q <= seen_q + 1'b1;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == S_IDLE)
		else $error("request taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid && count == 9'(fill_q))
		else $error("result count mismatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !accept)
		else $error("intake while busy");
endmodule
`default_nettype wire

// ===== sv/ilb_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module ilb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
